// ----- rtl/core/vsoc_pkg.sv -----
// Shared types, constants and discharge-curve tables for the pack voltage
// to state-of-charge pipeline. No dependencies.
package vsoc_pkg;

    // Field and register widths.
    localparam int MV_W       = 16;
    localparam int PCT_W      = 14;
    localparam int CHEM_W     = 3;
    localparam int CELLS_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHEMISTRY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CELLS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PACK_MIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PACK_MAX  = 2'd3;

    // Chemistry codes. Codes above lead-acid are treated as unknown.
    localparam logic [CHEM_W-1:0] CHEM_UNKNOWN   = 3'd0;
    localparam logic [CHEM_W-1:0] CHEM_LIION     = 3'd1;
    localparam logic [CHEM_W-1:0] CHEM_LIPO      = 3'd2;
    localparam logic [CHEM_W-1:0] CHEM_LIFEPO4   = 3'd3;
    localparam logic [CHEM_W-1:0] CHEM_NIMH      = 3'd4;
    localparam logic [CHEM_W-1:0] CHEM_LEAD_ACID = 3'd5;

    localparam logic [CELLS_W-1:0] MAX_SERIES = 5'd16;

    localparam logic [PCT_W-1:0] FULL_SCALE    = 14'd10000;
    localparam logic [MV_W-1:0]  FLAT_EMPTY_MV = 16'd3000;
    localparam logic [MV_W-1:0]  FLAT_FULL_MV  = 16'd4200;
    localparam logic [MV_W-1:0]  FLAT_SPAN_MV  = FLAT_FULL_MV - FLAT_EMPTY_MV;

    // Pipelined restoring divider geometry. The dividend must stay below
    // divisor * 2**QUOT_W, which every use in this block guarantees.
    localparam int DIVIDEND_W         = 30;
    localparam int DIVISOR_W          = 16;
    localparam int QUOT_W             = 16;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = QUOT_W / DIV_BITS_PER_STAGE;

    // Discharge curves: one row per chemistry that uses a curve.
    localparam int CURVE_POINTS = 13;
    localparam int CURVE_COUNT  = 3;
    localparam int CURVE_SEL_W  = $clog2(CURVE_COUNT);
    localparam int SEG_COUNT    = CURVE_POINTS - 1;
    localparam int PT_W         = $clog2(CURVE_POINTS);

    localparam logic [PCT_W-1:0] CURVE_SOC [CURVE_POINTS] = '{
        14'd0, 14'd500, 14'd1000, 14'd2000, 14'd3000, 14'd4000, 14'd5000,
        14'd6000, 14'd7000, 14'd8000, 14'd9000, 14'd9500, 14'd10000
    };

    localparam logic [MV_W-1:0] CURVE_MV [CURVE_COUNT][CURVE_POINTS] = '{
        '{16'd2850, 16'd3210, 16'd3320, 16'd3430, 16'd3490, 16'd3600, 16'd3680,
          16'd3750, 16'd3810, 16'd3890, 16'd4030, 16'd4110, 16'd4170},
        '{16'd3150, 16'd3260, 16'd3370, 16'd3480, 16'd3590, 16'd3680, 16'd3730,
          16'd3780, 16'd3830, 16'd3910, 16'd4050, 16'd4110, 16'd4170},
        '{16'd2430, 16'd2840, 16'd3040, 16'd3150, 16'd3200, 16'd3240, 16'd3260,
          16'd3290, 16'd3310, 16'd3330, 16'd3360, 16'd3380, 16'd3380}
    };

    // One finished result as it travels through the output buffer.
    typedef struct packed {
        logic             config_fault;
        logic             linear_mode;
        logic [PCT_W-1:0] charge;
    } result_t;

endpackage

// ----- rtl/core/voltage_to_state_of_charge_top.sv -----
// An accepted beat passes through stages A and B, an 8-stage divider, stages C to E, a
// second 8-stage divider, stage F and the output register before m_tvalid rises.
// Throughput: one beat per cycle; every stage takes a new beat each cycle, and a stall
// only freezes the pipeline in place. Reset: aresetn is synchronous and active low; it
// clears the configuration registers to zero and empties the pipeline and output buffer.
// Depends on vsoc_pkg, vsoc_div and vsoc_skid.
module voltage_to_state_of_charge_top
    import vsoc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input channel. s_tdata: [15:0] pack_mv.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,
    // Result channel. m_tdata: [13:0] charge_centipercent, upper bits zero.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,
    // m_tuser: [0] linear_mode, [1] config_fault.
    output logic [1:0]            m_tuser,
    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Sideband that rides beside the first divider.
    typedef struct packed {
        logic [CHEM_W-1:0] chem;
        logic              lin;
        logic              fault;
        logic              pos;
        logic              sat;
    } sb1_t;

    // Sideband that rides beside the second divider.
    typedef struct packed {
        logic             direct;
        logic [PCT_W-1:0] direct_val;
        logic [PCT_W-1:0] base;
        logic             lin;
        logic             fault;
    } sb2_t;

    // ------------------------------------------------------------------
    // Configuration registers. Write only while the block is idle; nothing enforces it.
    // ------------------------------------------------------------------
    logic [CHEM_W-1:0]  chem_reg;
    logic [CELLS_W-1:0] cells_reg;
    logic [MV_W-1:0]    min_reg;
    logic [MV_W-1:0]    max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chem_reg  <= '0;
            cells_reg <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_IDX_CHEMISTRY: chem_reg  <= cfg_wdata[CHEM_W-1:0];
                CFG_IDX_CELLS:     cells_reg <= cfg_wdata[CELLS_W-1:0];
                CFG_IDX_PACK_MIN:  min_reg   <= cfg_wdata[MV_W-1:0];
                CFG_IDX_PACK_MAX:  max_reg   <= cfg_wdata[MV_W-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances together whenever the output buffer has
    // room. The buffer's ready is a register, so m_tready never reaches
    // s_tready combinationally.
    logic en;
    assign s_tready = en;

    // ------------------------------------------------------------------
    // Stage A: mode decode and absolute differences for the linear scale.
    // ------------------------------------------------------------------
    logic               a_valid_reg;
    logic [MV_W-1:0]    a_v_reg;
    logic [CHEM_W-1:0]  a_chem_reg;
    logic               a_lin_reg, a_fault_reg, a_pos_reg;
    logic [MV_W-1:0]    a_absnum_reg, a_absden_reg;
    logic [CELLS_W-1:0] a_cells_reg;

    logic               a_lin_next, a_fault_next, a_pos_next;
    logic [MV_W-1:0]    a_v_next, a_absnum_next, a_absden_next;
    logic [CELLS_W-1:0] a_cells_next;

    always_comb begin
        a_v_next      = s_tdata[MV_W-1:0];
        a_lin_next    = (chem_reg == CHEM_UNKNOWN) || (chem_reg > CHEM_LEAD_ACID) ||
                        (cells_reg == '0);
        // An empty pack range is only a fault when the linear scale is in use.
        a_fault_next  = a_lin_next && (max_reg == min_reg);
        a_absnum_next = (a_v_next >= min_reg) ? a_v_next - min_reg : min_reg - a_v_next;
        a_absden_next = (max_reg >= min_reg) ? max_reg - min_reg : min_reg - max_reg;
        // Only a sample on the same side of the empty point as the full
        // point gives a nonzero charge; a reversed range inverts the scale.
        a_pos_next    = (a_v_next != min_reg) && !a_fault_next &&
                        ((a_v_next > min_reg) == (max_reg > min_reg));
        a_cells_next  = (cells_reg > MAX_SERIES) ? MAX_SERIES : cells_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_v_reg      <= a_v_next;
            a_chem_reg   <= chem_reg;
            a_lin_reg    <= a_lin_next;
            a_fault_reg  <= a_fault_next;
            a_pos_reg    <= a_pos_next;
            a_absnum_reg <= a_absnum_next;
            a_absden_reg <= a_absden_next;
            a_cells_reg  <= a_cells_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: saturation check and the scaling multiply that feeds the
    // first divider. In cell mode the divider splits the pack voltage
    // across the series cells instead.
    // ------------------------------------------------------------------
    logic                  b_valid_reg;
    logic [DIVIDEND_W-1:0] b_dividend_reg;
    logic [DIVISOR_W-1:0]  b_divisor_reg;
    sb1_t                  b_sb1_reg;

    logic                  b_sat;
    logic [DIVIDEND_W-1:0] b_dividend_next;
    logic [DIVISOR_W-1:0]  b_divisor_next;

    always_comb begin
        b_sat = (a_absnum_reg >= a_absden_reg);
        if (a_lin_reg) begin
            b_dividend_next = (a_pos_reg && !b_sat) ?
                              DIVIDEND_W'(a_absnum_reg) * DIVIDEND_W'(FULL_SCALE) : '0;
            b_divisor_next  = a_absden_reg;
        end else begin
            b_dividend_next = DIVIDEND_W'(a_v_reg);
            b_divisor_next  = DIVISOR_W'(a_cells_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_dividend_reg  <= b_dividend_next;
            b_divisor_reg   <= b_divisor_next;
            b_sb1_reg.chem  <= a_chem_reg;
            b_sb1_reg.lin   <= a_lin_reg;
            b_sb1_reg.fault <= a_fault_reg;
            b_sb1_reg.pos   <= a_pos_reg;
            b_sb1_reg.sat   <= b_sat;
        end
    end

    // ------------------------------------------------------------------
    // First divider: linear-scale quotient or per-cell voltage.
    // ------------------------------------------------------------------
    logic              div1_valid;
    logic [QUOT_W-1:0] div1_quot;
    sb1_t              sb1_pipe_reg [DIV_STAGES];

    vsoc_div u_div1 (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (b_valid_reg),
        .in_dividend  (b_dividend_reg),
        .in_divisor   (b_divisor_reg),
        .out_valid    (div1_valid),
        .out_quotient (div1_quot)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            sb1_pipe_reg[0] <= b_sb1_reg;
            for (int k = 1; k < DIV_STAGES; k++) begin
                sb1_pipe_reg[k] <= sb1_pipe_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage C: finish the linear result and compare the cell voltage
    // against every point of the selected discharge curve.
    // ------------------------------------------------------------------
    logic                   c_valid_reg;
    logic [MV_W-1:0]        c_cell_reg;
    logic                   c_lin_reg, c_fault_reg, c_curve_reg;
    logic [PCT_W-1:0]       c_lin_pct_reg;
    logic [CURVE_SEL_W-1:0] c_row_reg;
    logic [SEG_COUNT-1:0]   c_hit_reg;
    logic                   c_below_reg, c_above_reg;

    sb1_t                   c_sb;
    logic [MV_W-1:0]        c_cell;
    logic                   c_curve;
    logic [CURVE_SEL_W-1:0] c_row;
    logic [PCT_W-1:0]       c_lin_pct;
    logic [SEG_COUNT-1:0]   c_hit;

    always_comb begin
        c_sb    = sb1_pipe_reg[DIV_STAGES-1];
        c_cell  = div1_quot[MV_W-1:0];
        c_curve = (c_sb.chem == CHEM_LIION) || (c_sb.chem == CHEM_LIPO) ||
                  (c_sb.chem == CHEM_LIFEPO4);
        c_row   = c_curve ? CURVE_SEL_W'(c_sb.chem - CHEM_LIION) : '0;
        if (c_sb.fault || !c_sb.pos) begin
            c_lin_pct = '0;
        end else if (c_sb.sat) begin
            c_lin_pct = FULL_SCALE;
        end else begin
            c_lin_pct = div1_quot[PCT_W-1:0];
        end
        for (int i = 0; i < SEG_COUNT; i++) begin
            c_hit[i] = (c_cell >= CURVE_MV[c_row][i]) && (c_cell <= CURVE_MV[c_row][i+1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_cell_reg    <= c_cell;
            c_lin_reg     <= c_sb.lin;
            c_fault_reg   <= c_sb.fault;
            c_curve_reg   <= c_curve;
            c_lin_pct_reg <= c_lin_pct;
            c_row_reg     <= c_row;
            c_hit_reg     <= c_hit;
            c_below_reg   <= (c_cell <= CURVE_MV[c_row][0]);
            c_above_reg   <= (c_cell >= CURVE_MV[c_row][CURVE_POINTS-1]);
        end
    end

    // ------------------------------------------------------------------
    // Stage D: pick the first matching segment, or settle the result
    // outright when no interpolation is needed.
    // ------------------------------------------------------------------
    logic             d_valid_reg;
    logic [MV_W-1:0]  d_x_reg;
    logic [PCT_W-1:0] d_rise_reg;
    logic [MV_W-1:0]  d_span_reg;
    sb2_t             d_sb2_reg;

    logic [PT_W-1:0]  d_lo_idx, d_hi_idx;
    logic             d_found;
    logic [MV_W-1:0]  d_lo_mv, d_hi_mv, d_span, d_x;
    logic [PCT_W-1:0] d_rise;
    sb2_t             d_sb2;

    always_comb begin
        d_lo_idx = '0;
        for (int i = SEG_COUNT - 1; i >= 0; i--) begin
            if (c_hit_reg[i]) begin
                d_lo_idx = PT_W'(i);
            end
        end
        d_found  = |c_hit_reg;
        d_hi_idx = d_lo_idx + PT_W'(1);
        d_lo_mv  = CURVE_MV[c_row_reg][d_lo_idx];
        d_hi_mv  = CURVE_MV[c_row_reg][d_hi_idx];

        d_sb2.lin        = c_lin_reg;
        d_sb2.fault      = c_fault_reg;
        d_sb2.direct     = 1'b1;
        d_sb2.direct_val = '0;
        d_sb2.base       = '0;
        d_x              = '0;
        d_rise           = '0;
        d_span           = '0;

        if (c_lin_reg) begin
            d_sb2.direct_val = c_lin_pct_reg;
        end else if (c_curve_reg) begin
            if (c_above_reg && !c_below_reg) begin
                d_sb2.direct_val = FULL_SCALE;
            end else if (!c_below_reg && d_found) begin
                d_sb2.base = CURVE_SOC[d_lo_idx];
                d_span     = d_hi_mv - d_lo_mv;
                d_x        = c_cell_reg - d_lo_mv;
                d_rise     = CURVE_SOC[d_hi_idx] - CURVE_SOC[d_lo_idx];
                if (d_span == '0) begin
                    // A zero-width segment holds the charge at its start.
                    d_sb2.direct_val = CURVE_SOC[d_lo_idx];
                end else begin
                    d_sb2.direct = 1'b0;
                end
            end
        end else begin
            // NiMH and lead-acid use a straight per-cell scale.
            if (c_cell_reg >= FLAT_FULL_MV) begin
                d_sb2.direct_val = FULL_SCALE;
            end else if (c_cell_reg > FLAT_EMPTY_MV) begin
                d_sb2.direct = 1'b0;
                d_x          = c_cell_reg - FLAT_EMPTY_MV;
                d_rise       = FULL_SCALE;
                d_span       = FLAT_SPAN_MV;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_x_reg    <= d_x;
            d_rise_reg <= d_rise;
            d_span_reg <= d_span;
            d_sb2_reg  <= d_sb2;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: interpolation multiply that feeds the second divider.
    // ------------------------------------------------------------------
    logic                  e_valid_reg;
    logic [DIVIDEND_W-1:0] e_dividend_reg;
    logic [DIVISOR_W-1:0]  e_divisor_reg;
    sb2_t                  e_sb2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            e_dividend_reg <= d_sb2_reg.direct ? '0 :
                              DIVIDEND_W'(d_x_reg) * DIVIDEND_W'(d_rise_reg);
            e_divisor_reg  <= d_span_reg;
            e_sb2_reg      <= d_sb2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Second divider: interpolation step within the segment.
    // ------------------------------------------------------------------
    logic              div2_valid;
    logic [QUOT_W-1:0] div2_quot;
    sb2_t              sb2_pipe_reg [DIV_STAGES];

    vsoc_div u_div2 (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (e_valid_reg),
        .in_dividend  (e_dividend_reg),
        .in_divisor   (e_divisor_reg),
        .out_valid    (div2_valid),
        .out_quotient (div2_quot)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            sb2_pipe_reg[0] <= e_sb2_reg;
            for (int k = 1; k < DIV_STAGES; k++) begin
                sb2_pipe_reg[k] <= sb2_pipe_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage F: add the segment base and saturate to full scale.
    // ------------------------------------------------------------------
    logic        f_valid_reg;
    result_t     f_result_reg;

    sb2_t        f_sb;
    logic [QUOT_W:0] f_sum;
    result_t     f_result;

    always_comb begin
        f_sb  = sb2_pipe_reg[DIV_STAGES-1];
        f_sum = (QUOT_W + 1)'(f_sb.base) + (QUOT_W + 1)'(div2_quot);
        f_result.linear_mode  = f_sb.lin;
        f_result.config_fault = f_sb.fault;
        if (f_sb.direct) begin
            f_result.charge = f_sb.direct_val;
        end else if (f_sum > (QUOT_W + 1)'(FULL_SCALE)) begin
            f_result.charge = FULL_SCALE;
        end else begin
            f_result.charge = f_sum[PCT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_result_reg <= f_result;
        end
    end

    // Valid bits for the stages kept in this module.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= div1_valid;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= div2_valid;
        end
    end

    // ------------------------------------------------------------------
    // Output buffer. The stage D valid is not needed downstream beyond
    // stage E; stage C and D valid bits keep the chain aligned.
    // ------------------------------------------------------------------
    result_t out_result;
    logic    out_valid;

    vsoc_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid_reg),
        .in_data   (f_result_reg),
        .in_ready  (en),
        .out_valid (out_valid),
        .out_data  (out_result),
        .out_ready (m_tready)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {(16 - PCT_W)'(0), out_result.charge};
    assign m_tuser  = {out_result.config_fault, out_result.linear_mode};

`ifndef SYNTHESIS
    // A configuration fault only arises in linear mode and forces zero charge.
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_result.config_fault) |->
        (out_result.linear_mode && (out_result.charge == '0)))
        else $error("config fault beat without linear mode or with nonzero charge");

    // Every delivered charge is saturated to full scale.
    a_charge_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_result.charge <= FULL_SCALE))
        else $error("charge beyond full scale");

    // The pipeline freezes only while a finished result waits at the output.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");
`endif

endmodule

// ----- rtl/core/vsoc_div.sv -----
// Pipelined restoring divider, two quotient bits per register stage.
// Depends on vsoc_pkg for its widths and depth.
module vsoc_div
    import vsoc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [DIVIDEND_W-1:0] in_dividend,
    input  logic [DIVISOR_W-1:0]  in_divisor,
    output logic                  out_valid,
    output logic [QUOT_W-1:0]     out_quotient
);

    typedef struct packed {
        logic [DIVISOR_W-1:0] rem;
        logic [QUOT_W-1:0]    bits;
        logic [DIVISOR_W-1:0] dvs;
    } div_state_t;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    function automatic div_state_t div_bit(div_state_t s);
        logic [DIVISOR_W:0] t;
        div_state_t         r;
        r = s;
        t = {s.rem, s.bits[QUOT_W-1]};
        if (t >= {1'b0, s.dvs}) begin
            t      = t - {1'b0, s.dvs};
            r.bits = {s.bits[QUOT_W-2:0], 1'b1};
        end else begin
            r.bits = {s.bits[QUOT_W-2:0], 1'b0};
        end
        r.rem = t[DIVISOR_W-1:0];
        return r;
    endfunction

    div_state_t            stage_reg  [DIV_STAGES];
    div_state_t            stage_next [DIV_STAGES];
    div_state_t            stage_src  [DIV_STAGES];
    logic [DIV_STAGES-1:0] valid_reg;

    always_comb begin
        div_state_t s;
        stage_src[0].rem  = DIVISOR_W'(in_dividend[DIVIDEND_W-1:QUOT_W]);
        stage_src[0].bits = in_dividend[QUOT_W-1:0];
        stage_src[0].dvs  = in_divisor;
        for (int k = 1; k < DIV_STAGES; k++) begin
            stage_src[k] = stage_reg[k-1];
        end
        for (int k = 0; k < DIV_STAGES; k++) begin
            s = stage_src[k];
            for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
                s = div_bit(s);
            end
            stage_next[k] = s;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg <= stage_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    assign out_valid    = valid_reg[DIV_STAGES-1];
    assign out_quotient = stage_reg[DIV_STAGES-1].bits;

endmodule

// ----- rtl/core/vsoc_skid.sv -----
// Two-entry output buffer that decouples the pipeline stall from the
// result channel ready. Depends on vsoc_pkg for the result type.
module vsoc_skid
    import vsoc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  result_t in_data,
    output logic    in_ready,
    output logic    out_valid,
    output result_t out_data,
    input  logic    out_ready
);

    logic    out_valid_reg;
    result_t out_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;
    logic    in_fire;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_fire;
            end
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_fire) begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
